[design/wvadsr_pkg.sv]
// Shared constants, types and widths for the wavetable voice with ADSR envelope.
package wvadsr_pkg;

  localparam int unsigned DEF_TABLE_DEPTH     = 2048;
  localparam int unsigned DEF_SAMPLE_RATE_HZ  = 48000;
  localparam int unsigned DEF_PHASE_FRAC_BITS = 16;

  localparam int CFG_W  = 24;
  localparam int LVL_W  = 16;
  localparam int NUM_W  = 41;
  localparam int DEN_W  = 24;
  localparam int QUO_W  = 17;
  localparam int SMP_W  = 16;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2,
    ACT_TABLE_WR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] RST_ATTACK  = 24'd480;
  localparam logic [CFG_W-1:0] RST_DECAY   = 24'd4800;
  localparam logic [LVL_W-1:0] RST_SUSTAIN = 16'd49152;
  localparam logic [CFG_W-1:0] RST_RELEASE = 24'd9600;

  localparam logic [QUO_W-1:0] FULL_SCALE = 17'h10000;

  // Frequencies of MIDI notes 0 to 11 in Q.20 Hz; higher octaves are shifts.
  localparam logic [23:0] BASE_FREQ_Q20 [12] = '{
    24'd8572947,  24'd9082720,  24'd9622807,  24'd10195009,
    24'd10801236, 24'd11443511, 24'd12123977, 24'd12844906,
    24'd13608704, 24'd14417920, 24'd15275254, 24'd16183568
  };

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[design/wvadsr_div.sv]
// Restoring divider that yields one quotient bit per cycle for the envelope.
module wvadsr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [wvadsr_pkg::NUM_W-1:0]    num_i,
  input  logic [wvadsr_pkg::DEN_W-1:0]    den_i,
  output logic                            done_o,
  output logic [wvadsr_pkg::QUO_W-1:0]    quo_o
);
  import wvadsr_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // The caller guarantees the quotient is below 2^QUO_W, so the upper
  // numerator bits already form a remainder smaller than the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1 -: DEN_W];
      quo_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[design/wavetable_voice_adsr_unit.sv]
// Top level of the wavetable voice: command decode, wave table, envelope and output.
// A playing tick that needs a divide goes from acceptance through the prep state
// (table read, divider start) and the divide, gain, multiply and output states; at
// a constant or zero level it skips the divide state, an idle tick goes straight to
// the output state, and output stalls hold it there. Words are taken only in idle,
// where notes and table writes complete. Reset clears voice state, not the table.
module wavetable_voice_adsr_unit #(
  parameter int unsigned TABLE_DEPTH     = wvadsr_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned SAMPLE_RATE_HZ  = wvadsr_pkg::DEF_SAMPLE_RATE_HZ,
  parameter int unsigned PHASE_FRAC_BITS = wvadsr_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [wvadsr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [6:0]                     note_number_i,
  input  logic [15:0]                    velocity_i,
  input  logic                           allow_tail_i,
  input  logic [10:0]                    table_index_i,
  input  logic signed [15:0]             table_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             sample_out_o,
  output logic                           voice_active_o
);
  import wvadsr_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int PW     = ADDR_W + PHASE_FRAC_BITS;
  localparam logic [63:0] PHASE_LIMIT = 64'(TABLE_DEPTH) << PHASE_FRAC_BITS;
  localparam logic [63:0] STEP_DEN    = 64'(SAMPLE_RATE_HZ) << (24 - PHASE_FRAC_BITS);
  localparam logic [PW:0] PH_LIM      = (PW + 1)'(PHASE_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_GAIN, S_MULT, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    ENV_ZERO, ENV_CONST, ENV_ATTACK, ENV_DECAY, ENV_RELEASE
  } env_e;

  // Phase step table, worked out at elaboration.
  logic [PW-1:0] step_rom [128];
  for (genvar n = 0; n < 128; n++) begin : g_rom
    localparam logic [63:0] FREQ = 64'(BASE_FREQ_Q20[n % 12]) << (n / 12 + 4);
    localparam logic [63:0] NUM  = FREQ * 64'(TABLE_DEPTH);
    localparam logic [63:0] STEP = ((NUM + STEP_DEN / 2) / STEP_DEN) % PHASE_LIMIT;
    assign step_rom[n] = PW'(STEP);
  end

  logic [CFG_W-1:0] attack_q, decay_q, release_q;
  logic [LVL_W-1:0] sustain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= RST_ATTACK;
      decay_q   <= RST_DECAY;
      sustain_q <= RST_SUSTAIN;
      release_q <= RST_RELEASE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ATTACK:  attack_q  <= cfg_wdata_i;
        CFG_DECAY:   decay_q   <= cfg_wdata_i;
        CFG_SUSTAIN: sustain_q <= cfg_wdata_i[LVL_W-1:0];
        CFG_RELEASE: release_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  state_e            state_q;
  logic              playing_q, releasing_q;
  logic [PW-1:0]     phase_q, step_q;
  logic [15:0]       gain_q;
  logic [31:0]       elapsed_q, rel_q;
  logic              live_q, done_q, sub_q;
  logic [QUO_W-1:0]  env_q;
  logic [32:0]       eg_q;
  logic signed [49:0] prod_q;
  logic [15:0]       rd_q;
  logic              out_valid_q, active_q;
  logic [SMP_W-1:0]  sample_q;

  logic [15:0] wave_mem [TABLE_DEPTH];

  logic in_acc, out_free, out_load;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;

  logic table_wr;
  logic rd_en;
  assign table_wr = in_acc && (action_e'(action_i) == ACT_TABLE_WR)
                    && (32'(table_index_i) < TABLE_DEPTH);
  assign rd_en    = (state_q == S_PREP);

  always_ff @(posedge clk_i) begin
    if (table_wr) begin
      wave_mem[ADDR_W'(table_index_i)] <= table_value_i;
    end
    if (rd_en) begin
      rd_q <= wave_mem[phase_q[PW-1 -: ADDR_W]];
    end
  end

  // Envelope segment and divider operands.
  logic [31:0]      e_minus_a;
  env_e             env_sel;
  logic [23:0]      mul_a;
  logic [16:0]      mul_b;
  logic [NUM_W-1:0] mul_p, div_num;
  logic [DEN_W-1:0] div_den;
  logic             rel_live;
  div_ctl_t         div_ctl;
  logic [QUO_W-1:0] div_quo;

  assign e_minus_a = elapsed_q - {8'd0, attack_q};
  assign rel_live  = rel_q < {8'd0, release_q};

  always_comb begin
    if (releasing_q) begin
      env_sel = rel_live ? ENV_RELEASE : ENV_ZERO;
    end else if (elapsed_q < {8'd0, attack_q}) begin
      env_sel = ENV_ATTACK;
    end else if (e_minus_a < {8'd0, decay_q}) begin
      env_sel = ENV_DECAY;
    end else begin
      env_sel = ENV_CONST;
    end
  end

  always_comb begin
    if (releasing_q) begin
      mul_a   = release_q - rel_q[23:0];
      mul_b   = {1'b0, sustain_q};
      div_den = release_q;
    end else begin
      mul_a   = e_minus_a[23:0];
      mul_b   = FULL_SCALE - {1'b0, sustain_q};
      div_den = (env_sel == ENV_ATTACK) ? attack_q : decay_q;
    end
    mul_p   = NUM_W'(mul_a * mul_b);
    div_num = (env_sel == ENV_ATTACK) ? {1'b0, elapsed_q[23:0], 16'd0} : mul_p;
  end

  assign div_ctl.start = (state_q == S_PREP)
                         && (env_sel != ENV_ZERO) && (env_sel != ENV_CONST);

  wvadsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctl.start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_ctl.done),
    .quo_o   (div_quo)
  );

  logic [PW:0]       phase_sum;
  logic [PW-1:0]     phase_next;
  logic signed [49:0] prod_adj;

  assign phase_sum  = {1'b0, phase_q} + {1'b0, step_q};
  assign phase_next = (phase_sum >= PH_LIM) ? PW'(phase_sum - PH_LIM) : phase_sum[PW-1:0];
  // Truncation toward zero: bias negative products before the shift.
  assign prod_adj   = prod_q + (prod_q[49] ? 50'sh0_FFFF_FFFF : 50'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      playing_q   <= 1'b0;
      releasing_q <= 1'b0;
      phase_q     <= '0;
      step_q      <= '0;
      gain_q      <= '0;
      elapsed_q   <= '0;
      rel_q       <= '0;
      live_q      <= 1'b0;
      done_q      <= 1'b0;
      sub_q       <= 1'b0;
      env_q       <= '0;
      eg_q        <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      sample_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (action_e'(action_i))
              ACT_NOTE_ON: begin
                step_q      <= step_rom[note_number_i];
                gain_q      <= velocity_i;
                phase_q     <= '0;
                elapsed_q   <= '0;
                rel_q       <= '0;
                playing_q   <= 1'b1;
                releasing_q <= 1'b0;
              end
              ACT_NOTE_OFF: begin
                if (allow_tail_i && playing_q && !releasing_q) begin
                  releasing_q <= 1'b1;
                  rel_q       <= '0;
                end else begin
                  playing_q   <= 1'b0;
                  releasing_q <= 1'b0;
                  gain_q      <= '0;
                end
              end
              ACT_TICK: begin
                live_q  <= playing_q;
                state_q <= playing_q ? S_PREP : S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          done_q <= releasing_q && !rel_live;
          sub_q  <= (env_sel == ENV_DECAY);
          if (env_sel == ENV_ZERO) begin
            env_q   <= '0;
            state_q <= S_GAIN;
          end else if (env_sel == ENV_CONST) begin
            env_q   <= {1'b0, sustain_q};
            state_q <= S_GAIN;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            env_q   <= sub_q ? FULL_SCALE - div_quo : div_quo;
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          eg_q    <= 33'(env_q * gain_q);
          state_q <= S_MULT;
        end
        S_MULT: begin
          prod_q  <= 50'($signed(rd_q) * $signed({1'b0, eg_q}));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            if (live_q) begin
              sample_q  <= prod_adj[47:32];
              active_q  <= !done_q;
              phase_q   <= phase_next;
              if (elapsed_q != '1) begin
                elapsed_q <= elapsed_q + 1'b1;
              end
              if (releasing_q && rel_q != '1) begin
                rel_q <= rel_q + 1'b1;
              end
              if (done_q) begin
                playing_q <= 1'b0;
              end
            end else begin
              sample_q <= '0;
              active_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_q;
  assign voice_active_o = active_q;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o)
    && $stable(voice_active_o)) else $error("stalled output word changed");
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> (state_q == S_DIV)) else $error("divider finished outside divide state");
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> (div_den != '0)) else $error("divider started with zero divisor");
  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, phase_q} < PH_LIM)) else $error("phase accumulator out of range");
`endif

endmodule
